[rtl/core/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands for the checker files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge, also while reset is high
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

// Property checked only outside of reset
`define ASSERT_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`endif

[rtl/core/sspi_pkg.sv]
// ----------------------------------------------------------------------------
// sspi_pkg
// Widths, reset values, register indexes and shared types of the
// state-space PI speed controller.
// ----------------------------------------------------------------------------
`default_nettype none

package sspi_pkg;

   // Field and register widths
   localparam int SPEED_W   = 16;   // Q8.8 speed and set point
   localparam int ERR_W     = SPEED_W + 1;
   localparam int COEF_W    = 18;   // Q4.14 coefficients
   localparam int CUR_W     = 16;   // Q8.8 current
   localparam int CSR_DATA_W = 18;
   localparam int CSR_IDX_W = 3;

   // Controller state width, 16 fraction bits
   localparam int STATE_W   = 32;

   // Scaling: err (8 frac) is lifted to 16 frac, products carry 30 frac bits
   localparam int ERR_SCALE   = 8;
   localparam int STATE_SHIFT = 14;  // 30 -> 16 fraction bits
   localparam int CUR_SHIFT   = 22;  // 30 -> 8 fraction bits

   // Accumulator widths
   localparam int PROD_W     = COEF_W + STATE_W;
   localparam int ERR_TERM_W = COEF_W + ERR_W + ERR_SCALE;
   localparam int BASE_W     = (PROD_W > ERR_TERM_W) ? PROD_W : ERR_TERM_W;
   localparam int ST_SUM_W   = BASE_W + 1;   // two terms
   localparam int CUR_SUM_W  = BASE_W + 2;   // three terms

   // Register reset values
   localparam logic signed [SPEED_W-1:0] RST_SET_POINT = 16'sd0;
   localparam logic signed [COEF_W-1:0]  RST_COEF_A0   = 18'sd16384;
   localparam logic signed [COEF_W-1:0]  RST_COEF_A1   = 18'sd8751;
   localparam logic signed [COEF_W-1:0]  RST_COEF_B0   = 18'sd2048;
   localparam logic signed [COEF_W-1:0]  RST_COEF_B1   = 18'sd19316;
   localparam logic signed [COEF_W-1:0]  RST_COEF_C0   = 18'sd5118;
   localparam logic signed [COEF_W-1:0]  RST_COEF_C1   = 18'sd19316;
   localparam logic signed [COEF_W-1:0]  RST_COEF_D    = 18'sd94144;

   // Register map
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SET_POINT = 3'd0,
      CSR_COEF_A0   = 3'd1,
      CSR_COEF_A1   = 3'd2,
      CSR_COEF_B0   = 3'd3,
      CSR_COEF_B1   = 3'd4,
      CSR_COEF_C0   = 3'd5,
      CSR_COEF_C1   = 3'd6,
      CSR_COEF_D    = 3'd7
   } csr_index_type;

   // Request opcodes
   typedef enum logic {
      OP_UPDATE = 1'b0,
      OP_CLEAR  = 1'b1
   } opcode_type;

   typedef logic signed [STATE_W-1:0] state_type;
   typedef logic signed [COEF_W-1:0]  coef_type;
   typedef logic signed [ERR_W-1:0]   err_type;

   // Control from the top level to one state lane
   typedef struct packed {
      logic update;   // take the next state this cycle
      logic clear;    // next state is zero
   } lane_ctrl_type;

endpackage

`default_nettype wire

[rtl/core/sspi_state_lane.sv]
// ----------------------------------------------------------------------------
// sspi_state_lane
// One controller state: holds x and updates x = round(a*x + b*err)
// with saturation to the state width, or clears it to zero.
// ----------------------------------------------------------------------------
`default_nettype none

module sspi_state_lane (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire sspi_pkg::lane_ctrl_type ctrl,
   input  wire sspi_pkg::coef_type     coef_a,
   input  wire sspi_pkg::coef_type     coef_b,
   input  wire sspi_pkg::err_type      err,
   output sspi_pkg::state_type         state,
   output logic                        clip
);

   localparam int SH_W = sspi_pkg::ST_SUM_W - sspi_pkg::STATE_SHIFT;
   localparam int BE_W = sspi_pkg::COEF_W + sspi_pkg::ERR_W;
   localparam logic signed [sspi_pkg::ST_SUM_W-1:0] ROUND_HALF =
      sspi_pkg::ST_SUM_W'(1) <<< (sspi_pkg::STATE_SHIFT - 1);

   sspi_pkg::state_type                     state_ff, state_in;
   logic signed [sspi_pkg::PROD_W-1:0]      feedback;
   logic signed [BE_W-1:0]                  prod_be;
   logic signed [sspi_pkg::ERR_TERM_W-1:0]  err_term;
   logic signed [sspi_pkg::ST_SUM_W-1:0]    sum;
   logic signed [SH_W-1:0]                  shifted;
   logic        [SH_W-sspi_pkg::STATE_W:0]  upper;
   logic                                    ovf;
   sspi_pkg::state_type                     limit;

   // a*x and b*err, both with 30 fraction bits
   assign feedback = coef_a * state_ff;
   assign prod_be  = coef_b * err;
   assign err_term = {prod_be, {sspi_pkg::ERR_SCALE{1'b0}}};

   // round half up to 16 fraction bits
   assign sum     = sspi_pkg::ST_SUM_W'(feedback) + sspi_pkg::ST_SUM_W'(err_term)
                  + ROUND_HALF;
   assign shifted = sum[sspi_pkg::ST_SUM_W-1:sspi_pkg::STATE_SHIFT];

   // saturate to the state range
   assign upper = shifted[SH_W-1:sspi_pkg::STATE_W-1];
   assign ovf   = !((&upper) || !(|upper));
   assign limit = shifted[SH_W-1] ? {1'b1, {(sspi_pkg::STATE_W-1){1'b0}}}
                                  : {1'b0, {(sspi_pkg::STATE_W-1){1'b1}}};

   always_comb begin
      if (ctrl.clear) begin
         state_in = '0;
      end else if (ovf) begin
         state_in = limit;
      end else begin
         state_in = shifted[sspi_pkg::STATE_W-1:0];
      end
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (ctrl.update) begin
         state_ff <= state_in;
      end
   end

   assign state = state_ff;
   assign clip  = ovf;

endmodule

`default_nettype wire

[rtl/core/state_space_pi_speed_controller_core.sv]
// ----------------------------------------------------------------------------
// state_space_pi_speed_controller_core
// Two-state discrete speed controller: current = C0*x0 + C1*x1 + D*err,
// then xi = Ai*xi + Bi*err, with rounding and saturation; a clear zeroes both.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  req     | in        | req_valid/req_stall  | opcode, measured_speed
//  rsp     | out       | rsp_valid/rsp_stall  | current_command, saturated
//  csr     | in        | csr_wr_en            | csr_index, csr_wr_data
//
//  One beat per cycle sustained while rsp is not stalled; a req beat passes
//  the input register, then the result register, on its way to rsp.
//  The state multiply-add is combinational, so updates run back to back.
//  Synchronous reset loads register defaults and clears both states.
//  A stalled rsp beat holds; req stalls only when both registers are full.
// ----------------------------------------------------------------------------
`default_nettype none

module state_space_pi_speed_controller_core (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // request channel
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic                                 req_opcode,
   input  wire logic signed [sspi_pkg::SPEED_W-1:0]  req_measured_speed,
   // result channel
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic signed [sspi_pkg::CUR_W-1:0]         rsp_current_command,
   output logic                                      rsp_saturated,
   // configuration
   input  wire logic                                 csr_wr_en,
   input  wire logic [sspi_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [sspi_pkg::CSR_DATA_W-1:0]      csr_wr_data
);

   localparam int DE_W   = sspi_pkg::COEF_W + sspi_pkg::ERR_W;
   localparam int CSH_W  = sspi_pkg::CUR_SUM_W - sspi_pkg::CUR_SHIFT;
   localparam logic signed [sspi_pkg::CUR_SUM_W-1:0] CUR_ROUND =
      sspi_pkg::CUR_SUM_W'(1) <<< (sspi_pkg::CUR_SHIFT - 1);

   // configuration registers
   logic signed [sspi_pkg::SPEED_W-1:0] set_point_ff;
   sspi_pkg::coef_type coef_a0_ff, coef_a1_ff, coef_b0_ff, coef_b1_ff;
   sspi_pkg::coef_type coef_c0_ff, coef_c1_ff, coef_d_ff;

   // input stage
   logic              in_valid_ff, in_valid_in;
   logic              in_clear_ff;
   sspi_pkg::err_type in_err_ff;
   logic              accept, advance;

   // result stage
   logic                              rsp_valid_ff, rsp_valid_in;
   logic signed [sspi_pkg::CUR_W-1:0] rsp_cmd_ff, rsp_cmd_in;
   logic                              rsp_sat_ff, rsp_sat_in;

   // datapath
   sspi_pkg::state_type                    x0, x1;
   logic                                   clip0, clip1;
   sspi_pkg::lane_ctrl_type                lane_ctrl;
   logic signed [sspi_pkg::PROD_W-1:0]     prod_c0, prod_c1;
   logic signed [DE_W-1:0]                 prod_d;
   logic signed [sspi_pkg::ERR_TERM_W-1:0] d_term;
   logic signed [sspi_pkg::CUR_SUM_W-1:0]  cur_sum;
   logic signed [CSH_W-1:0]                cur_shifted;
   logic        [CSH_W-sspi_pkg::CUR_W:0]  cur_upper;
   logic                                   cur_ovf;
   logic signed [sspi_pkg::CUR_W-1:0]      cur_sat;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         set_point_ff <= sspi_pkg::RST_SET_POINT;
         coef_a0_ff   <= sspi_pkg::RST_COEF_A0;
         coef_a1_ff   <= sspi_pkg::RST_COEF_A1;
         coef_b0_ff   <= sspi_pkg::RST_COEF_B0;
         coef_b1_ff   <= sspi_pkg::RST_COEF_B1;
         coef_c0_ff   <= sspi_pkg::RST_COEF_C0;
         coef_c1_ff   <= sspi_pkg::RST_COEF_C1;
         coef_d_ff    <= sspi_pkg::RST_COEF_D;
      end else if (csr_wr_en) begin
         unique case (sspi_pkg::csr_index_type'(csr_index))
            sspi_pkg::CSR_SET_POINT: set_point_ff <= csr_wr_data[sspi_pkg::SPEED_W-1:0];
            sspi_pkg::CSR_COEF_A0:   coef_a0_ff   <= csr_wr_data[sspi_pkg::COEF_W-1:0];
            sspi_pkg::CSR_COEF_A1:   coef_a1_ff   <= csr_wr_data[sspi_pkg::COEF_W-1:0];
            sspi_pkg::CSR_COEF_B0:   coef_b0_ff   <= csr_wr_data[sspi_pkg::COEF_W-1:0];
            sspi_pkg::CSR_COEF_B1:   coef_b1_ff   <= csr_wr_data[sspi_pkg::COEF_W-1:0];
            sspi_pkg::CSR_COEF_C0:   coef_c0_ff   <= csr_wr_data[sspi_pkg::COEF_W-1:0];
            sspi_pkg::CSR_COEF_C1:   coef_c1_ff   <= csr_wr_data[sspi_pkg::COEF_W-1:0];
            sspi_pkg::CSR_COEF_D:    coef_d_ff    <= csr_wr_data[sspi_pkg::COEF_W-1:0];
         endcase
      end
   end

   // handshake: the input register moves on when the result slot frees up
   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   // input register: error is formed on the way in
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_clear_ff <= (sspi_pkg::opcode_type'(req_opcode) == sspi_pkg::OP_CLEAR);
         in_err_ff   <= sspi_pkg::ERR_W'(set_point_ff) - sspi_pkg::ERR_W'(req_measured_speed);
      end
   end

   // state lanes
   assign lane_ctrl.update = advance;
   assign lane_ctrl.clear  = in_clear_ff;

   sspi_state_lane u_lane0 (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (lane_ctrl),
      .coef_a (coef_a0_ff),
      .coef_b (coef_b0_ff),
      .err    (in_err_ff),
      .state  (x0),
      .clip   (clip0)
   );

   sspi_state_lane u_lane1 (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (lane_ctrl),
      .coef_a (coef_a1_ff),
      .coef_b (coef_b1_ff),
      .err    (in_err_ff),
      .state  (x1),
      .clip   (clip1)
   );

   // output current from the states before this update
   assign prod_c0 = coef_c0_ff * x0;
   assign prod_c1 = coef_c1_ff * x1;
   assign prod_d  = coef_d_ff * in_err_ff;
   assign d_term  = {prod_d, {sspi_pkg::ERR_SCALE{1'b0}}};

   assign cur_sum = sspi_pkg::CUR_SUM_W'(prod_c0) + sspi_pkg::CUR_SUM_W'(prod_c1)
                  + sspi_pkg::CUR_SUM_W'(d_term) + CUR_ROUND;
   assign cur_shifted = cur_sum[sspi_pkg::CUR_SUM_W-1:sspi_pkg::CUR_SHIFT];

   // saturate to Q8.8
   assign cur_upper = cur_shifted[CSH_W-1:sspi_pkg::CUR_W-1];
   assign cur_ovf   = !((&cur_upper) || !(|cur_upper));

   always_comb begin
      if (!cur_ovf) begin
         cur_sat = cur_shifted[sspi_pkg::CUR_W-1:0];
      end else if (cur_shifted[CSH_W-1]) begin
         cur_sat = {1'b1, {(sspi_pkg::CUR_W-1){1'b0}}};
      end else begin
         cur_sat = {1'b0, {(sspi_pkg::CUR_W-1){1'b1}}};
      end
   end

   // result register
   always_comb begin
      if (in_clear_ff) begin
         rsp_cmd_in = '0;
         rsp_sat_in = 1'b0;
      end else begin
         rsp_cmd_in = cur_sat;
         rsp_sat_in = cur_ovf || clip0 || clip1;
      end
   end

   always_comb begin
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_cmd_ff <= rsp_cmd_in;
         rsp_sat_ff <= rsp_sat_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_current_command = rsp_cmd_ff;
   assign rsp_saturated       = rsp_sat_ff;

endmodule

`default_nettype wire

[rtl/core/sspi_checker.sv]
// ----------------------------------------------------------------------------
// sspi_checker
// Port-level checks of the speed controller core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module sspi_checker (
   input wire logic                                 clock,
   input wire logic                                 reset,
   input wire logic                                 req_valid,
   input wire logic                                 req_stall,
   input wire logic                                 rsp_valid,
   input wire logic                                 rsp_stall,
   input wire logic signed [sspi_pkg::CUR_W-1:0]    rsp_current_command,
   input wire logic                                 rsp_saturated
);

   // pipeline empty and not stalling right after reset
   `ASSERT_ALWAYS(a_reset_empty, clock, reset |=> (!rsp_valid && !req_stall), "not empty after reset")

   // with no result waiting, the request side is never held off
   `ASSERT_RST(a_no_stall_when_empty, clock, reset, !rsp_valid |-> !req_stall, "stall with empty output")

   // an accepted beat moves from the input register into the result register when the output is not stalled
   `ASSERT_RST(a_latency, clock, reset, (req_valid && !req_stall) ##1 !rsp_stall |=> rsp_valid, "result beat missing")

   // a stalled result beat holds its payload
   `ASSERT_RST(a_rsp_hold, clock, reset, (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_current_command) && $stable(rsp_saturated)), "stalled result changed")

endmodule

bind state_space_pi_speed_controller_core sspi_checker u_sspi_checker (.*);

`default_nettype wire
